[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and character codes for the string body decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int UNIT_W      = 16;
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        KIND_UNIT     = 2'd0,
        KIND_QUOTE    = 2'd1,
        KIND_ERROR    = 2'd2,
        KIND_UNCLOSED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX0  = 3'd2,
        MODE_HEX1  = 3'd3,
        MODE_HEX2  = 3'd4,
        MODE_HEX3  = 3'd5
    } mode_t;

    localparam logic [UNIT_W-1:0] CHAR_QUOTE     = 16'h0022;
    localparam logic [UNIT_W-1:0] CHAR_BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CHAR_SLASH     = 16'h002F;
    localparam logic [UNIT_W-1:0] CHAR_SPACE     = 16'h0020;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_B   = 16'h0062;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_F   = 16'h0066;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_N   = 16'h006E;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_R   = 16'h0072;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_T   = 16'h0074;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_U   = 16'h0075;
    localparam logic [UNIT_W-1:0] CHAR_DIGIT_0   = 16'h0030;
    localparam logic [UNIT_W-1:0] CHAR_DIGIT_9   = 16'h0039;
    localparam logic [UNIT_W-1:0] CHAR_UPPER_A   = 16'h0041;
    localparam logic [UNIT_W-1:0] CHAR_UPPER_F   = 16'h0046;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_A   = 16'h0061;
    localparam logic [UNIT_W-1:0] CHAR_BS        = 16'h0008;
    localparam logic [UNIT_W-1:0] CHAR_FF        = 16'h000C;
    localparam logic [UNIT_W-1:0] CHAR_LF        = 16'h000A;
    localparam logic [UNIT_W-1:0] CHAR_CR        = 16'h000D;
    localparam logic [UNIT_W-1:0] CHAR_TAB       = 16'h0009;

    typedef struct packed {
        kind_t             kind;
        logic [UNIT_W-1:0] unit;
    } res_t;

    typedef struct packed {
        logic [1:0]                   count;
        res_t [MAX_RESULTS-1:0]       res;
        mode_t                        mode;
        logic [UNIT_W-1:0]            acc;
    } decode_t;

endpackage

[rtl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Decodes one code unit against the current escape state and yields up to
// three results together with the next escape state.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic [15:0]      code_unit,
    input  logic             end_of_buffer,
    input  jsu_pkg::mode_t   mode,
    input  logic [15:0]      acc,
    output jsu_pkg::decode_t dec
);

    logic       is_digit;
    logic       is_letter;
    logic       hex_ok;
    logic [3:0] hex_v;

    assign is_digit  = (code_unit >= jsu_pkg::CHAR_DIGIT_0) &&
                       (code_unit <= jsu_pkg::CHAR_DIGIT_9);
    assign is_letter = ((code_unit >= jsu_pkg::CHAR_UPPER_A) &&
                        (code_unit <= jsu_pkg::CHAR_UPPER_F)) ||
                       ((code_unit >= jsu_pkg::CHAR_LOWER_A) &&
                        (code_unit <= jsu_pkg::CHAR_LOWER_F));
    assign hex_ok    = is_digit || is_letter;
    assign hex_v     = is_digit ? code_unit[3:0] : ({1'b0, code_unit[2:0]} + 4'd9);

    always_comb begin
        logic [1:0]  n;
        logic        ended;
        logic        do_plain;
        logic        known;
        logic [15:0] mapped;
        logic [15:0] acc_shift;

        dec       = '0;
        n         = 2'd0;
        ended     = 1'b0;
        do_plain  = 1'b0;
        known     = 1'b1;
        mapped    = '0;
        acc_shift = {acc[11:0], hex_v};
        dec.mode  = mode;
        dec.acc   = acc;

        unique case (code_unit)
            jsu_pkg::CHAR_QUOTE:     mapped = jsu_pkg::CHAR_QUOTE;
            jsu_pkg::CHAR_BACKSLASH: mapped = jsu_pkg::CHAR_BACKSLASH;
            jsu_pkg::CHAR_SLASH:     mapped = jsu_pkg::CHAR_SLASH;
            jsu_pkg::CHAR_LOWER_B:   mapped = jsu_pkg::CHAR_BS;
            jsu_pkg::CHAR_LOWER_F:   mapped = jsu_pkg::CHAR_FF;
            jsu_pkg::CHAR_LOWER_N:   mapped = jsu_pkg::CHAR_LF;
            jsu_pkg::CHAR_LOWER_R:   mapped = jsu_pkg::CHAR_CR;
            jsu_pkg::CHAR_LOWER_T:   mapped = jsu_pkg::CHAR_TAB;
            default:                 known  = 1'b0;
        endcase

        unique case (mode)
            jsu_pkg::MODE_ESC: begin
                dec.mode = jsu_pkg::MODE_PLAIN;
                if (code_unit == jsu_pkg::CHAR_LOWER_U) begin
                    dec.acc = '0;
                    if (end_of_buffer) begin
                        dec.res[n] = '{kind: jsu_pkg::KIND_ERROR, unit: '0};
                        n          = n + 2'd1;
                        ended      = 1'b1;
                    end else begin
                        dec.mode = jsu_pkg::MODE_HEX0;
                    end
                end else if (known) begin
                    dec.res[n] = '{kind: jsu_pkg::KIND_UNIT, unit: mapped};
                    n          = n + 2'd1;
                end else begin
                    dec.res[n] = '{kind: jsu_pkg::KIND_UNIT, unit: jsu_pkg::CHAR_BACKSLASH};
                    n          = n + 2'd1;
                    do_plain   = 1'b1;
                end
            end
            jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1,
            jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
                if (!hex_ok) begin
                    dec.res[n] = '{kind: jsu_pkg::KIND_ERROR, unit: '0};
                    n          = n + 2'd1;
                    dec.mode   = jsu_pkg::MODE_PLAIN;
                    dec.acc    = '0;
                    ended      = 1'b1;
                end else if (mode == jsu_pkg::MODE_HEX3) begin
                    dec.res[n] = '{kind: jsu_pkg::KIND_UNIT, unit: acc_shift};
                    n          = n + 2'd1;
                    dec.mode   = jsu_pkg::MODE_PLAIN;
                    dec.acc    = '0;
                end else if (end_of_buffer) begin
                    dec.res[n] = '{kind: jsu_pkg::KIND_ERROR, unit: '0};
                    n          = n + 2'd1;
                    dec.mode   = jsu_pkg::MODE_PLAIN;
                    dec.acc    = '0;
                    ended      = 1'b1;
                end else begin
                    dec.acc  = acc_shift;
                    dec.mode = jsu_pkg::mode_t'(mode + 3'd1);
                end
            end
            default: begin
                dec.mode = jsu_pkg::MODE_PLAIN;
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            priority if (code_unit == jsu_pkg::CHAR_QUOTE) begin
                dec.res[n] = '{kind: jsu_pkg::KIND_QUOTE, unit: '0};
                n          = n + 2'd1;
                dec.mode   = jsu_pkg::MODE_PLAIN;
                dec.acc    = '0;
                ended      = 1'b1;
            end else if (code_unit == jsu_pkg::CHAR_BACKSLASH) begin
                if (end_of_buffer) begin
                    dec.res[n] = '{kind: jsu_pkg::KIND_UNIT, unit: jsu_pkg::CHAR_BACKSLASH};
                    n          = n + 2'd1;
                end else begin
                    dec.mode = jsu_pkg::MODE_ESC;
                end
            end else if (code_unit < jsu_pkg::CHAR_SPACE) begin
                dec.res[n] = '{kind: jsu_pkg::KIND_ERROR, unit: '0};
                n          = n + 2'd1;
                dec.mode   = jsu_pkg::MODE_PLAIN;
                dec.acc    = '0;
                ended      = 1'b1;
            end else begin
                dec.res[n] = '{kind: jsu_pkg::KIND_UNIT, unit: code_unit};
                n          = n + 2'd1;
            end
        end

        if (end_of_buffer && !ended) begin
            dec.res[n] = '{kind: jsu_pkg::KIND_UNCLOSED, unit: '0};
            n          = n + 2'd1;
            dec.mode   = jsu_pkg::MODE_PLAIN;
            dec.acc    = '0;
        end

        dec.count = n;
    end

endmodule

[rtl/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// JSON string unescape
// Streams the body of a JSON string and emits decoded code units.
// ----------------------------------------------------------------------------
// The input channel (s_) carries one UTF-16 code unit per transaction with
// a flag marking the last unit of the buffer. The result channel (m_) carries
// decoded units, a closing quote marker, an error marker or an unclosed-buffer
// marker; m_last_of_run flags the final result caused by one input unit.
// One input unit yields zero to three results.
// An accepted unit is held in an input register, decoded by short logic and
// loaded into a result group register, which presents its first result.
// One input unit is taken per cycle while the receiver is ready and each
// unit yields at most one result; a unit with more results holds the result
// channel until all of them are taken, which sets the sustained rate.
// When the receiver stalls, the input register still takes one more unit,
// then s_ready falls until the result group drains.
// A synchronous reset on aresetn drops all pending results and returns the
// decoder to plain text mode with a cleared hex accumulator.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_decoded_unit,
    output logic        m_last_of_run
);

    logic                                  in_valid_reg, in_valid_next;
    logic [15:0]                           in_unit_reg;
    logic                                  in_eob_reg;
    jsu_pkg::mode_t                        mode_reg, mode_next;
    logic [15:0]                           acc_reg, acc_next;
    logic                                  grp_valid_reg, grp_valid_next;
    logic [1:0]                            grp_count_reg, grp_count_next;
    logic [1:0]                            grp_idx_reg, grp_idx_next;
    jsu_pkg::res_t [jsu_pkg::MAX_RESULTS-1:0] grp_res_reg, grp_res_next;

    jsu_pkg::decode_t dec;
    jsu_pkg::res_t    cur_res;
    logic             grp_last;
    logic             grp_free;
    logic             move;
    logic             s_fire;
    logic             m_fire;

    jsu_decode u_decode (
        .code_unit     (in_unit_reg),
        .end_of_buffer (in_eob_reg),
        .mode          (mode_reg),
        .acc           (acc_reg),
        .dec           (dec)
    );

    assign grp_last = (grp_idx_reg == (grp_count_reg - 2'd1));
    assign grp_free = !grp_valid_reg || (m_ready && grp_last);
    assign move     = in_valid_reg && grp_free;
    assign s_ready  = !in_valid_reg || move;
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = grp_valid_reg && m_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (move) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        grp_valid_next = grp_valid_reg;
        grp_count_next = grp_count_reg;
        grp_idx_next   = grp_idx_reg;
        grp_res_next   = grp_res_reg;
        if (move) begin
            mode_next      = dec.mode;
            acc_next       = dec.acc;
            grp_valid_next = (dec.count != 2'd0);
            grp_count_next = dec.count;
            grp_idx_next   = 2'd0;
            grp_res_next   = dec.res;
        end else if (m_fire) begin
            if (grp_last) begin
                grp_valid_next = 1'b0;
            end else begin
                grp_idx_next = grp_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            mode_reg      <= jsu_pkg::MODE_PLAIN;
            acc_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            grp_valid_reg <= grp_valid_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_unit_reg <= s_code_unit;
            in_eob_reg  <= s_end_of_buffer;
        end
        grp_count_reg <= grp_count_next;
        grp_idx_reg   <= grp_idx_next;
        grp_res_reg   <= grp_res_next;
    end

    assign cur_res        = grp_res_reg[grp_idx_reg];
    assign m_valid        = grp_valid_reg;
    assign m_kind         = cur_res.kind;
    assign m_decoded_unit = cur_res.unit;
    assign m_last_of_run  = grp_last;

endmodule

[rtl/jsu_checker.sv]
// ----------------------------------------------------------------------------
// JSON string unescape checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [15:0] m_decoded_unit,
    input logic        m_last_of_run
);

    // A stalled result transaction keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) &&
        $stable(m_decoded_unit) && $stable(m_last_of_run))
        else $error("stalled result changed");

    // Markers carry no code unit.
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != jsu_pkg::KIND_UNIT) |-> (m_decoded_unit == 16'h0000))
        else $error("marker result has a nonzero unit");

    // Quote, error and unclosed markers always close the run of one input.
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != jsu_pkg::KIND_UNIT) |-> m_last_of_run)
        else $error("marker result is not last of its run");

    // Reset drops any pending result.
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_decoded_unit (m_decoded_unit),
    .m_last_of_run  (m_last_of_run)
);
